@@ rtl/core/dch_pkg.sv @@
// dch_pkg: widths, types, structs and helper functions shared by the
// dominant colour histogram modules. No dependencies.

package dch_pkg;

  localparam int COUNT_BITS = 20;
  localparam int PEAK_BITS  = 20;
  localparam int EPOCH_BITS = 8;
  localparam int CH_BITS    = 8;
  localparam int QNT_BITS   = 5;
  localparam int BIN_BITS   = 3 * QNT_BITS;
  localparam int MINB_BITS  = 10;
  localparam int NUM_BINS   = 1 << BIN_BITS;
  localparam int CNT_EXT    = (COUNT_BITS > PEAK_BITS) ? COUNT_BITS : PEAK_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [PEAK_BITS-1:0]  peak_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;
  typedef logic [BIN_BITS-1:0]   bin_t;
  typedef logic [CH_BITS-1:0]    chan_t;
  typedef logic [MINB_BITS-1:0]  minb_t;

  localparam count_t COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam peak_t  PEAK_MAX   = {PEAK_BITS{1'b1}};
  localparam epoch_t EPOCH_MAX  = {EPOCH_BITS{1'b1}};
  localparam epoch_t EPOCH_INIT = epoch_t'(1);
  localparam minb_t  MINB_RESET = minb_t'(60);
  localparam chan_t  GREY_LEVEL = chan_t'(128);

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } color_t;

  typedef struct packed {
    epoch_t tag;
    count_t cnt;
  } entry_t;

  // bin update side -> colour store
  typedef struct packed {
    logic   wr_en;
    bin_t   wr_bin;
    color_t wr_color;
    logic   rq_valid;
    bin_t   rq_bin;
    logic   rq_fwd;
    color_t rq_fwd_color;
    logic   rq_found;
    peak_t  rq_peak;
  } color_req_t;

  typedef struct packed {
    logic busy;
    logic last_in_s1;
  } upd_status_t;

  typedef struct packed {
    color_t color;
    logic   found;
    peak_t  peak;
  } result_t;

  function automatic bin_t bin_of(color_t c);
    return {c.red[CH_BITS-1 -: QNT_BITS], c.green[CH_BITS-1 -: QNT_BITS],
            c.blue[CH_BITS-1 -: QNT_BITS]};
  endfunction

  function automatic peak_t sat_peak(count_t c);
    logic [CNT_EXT-1:0] ext;
    ext = CNT_EXT'(c);
    if (ext > CNT_EXT'(PEAK_MAX)) return PEAK_MAX;
    return ext[PEAK_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/dch_bin_update.sv @@
// dch_bin_update: bin count memory with read-modify-write, forwarding,
// epoch tags, clearing sweep and running best tracking. Uses dch_pkg.

module dch_bin_update (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc_i,
  input  dch_pkg::color_t      color_i,
  input  logic                 last_i,
  input  dch_pkg::minb_t       min_bright_i,
  output dch_pkg::color_req_t  req_o,
  output dch_pkg::upd_status_t sts_o
);

  dch_pkg::entry_t cnt_mem [dch_pkg::NUM_BINS];
  dch_pkg::entry_t rd_r;

  logic            s1_v_r, s1_v_nxt;
  logic            s1_last_r;
  logic            s1_q_r;
  dch_pkg::bin_t   s1_bin_r;
  dch_pkg::color_t s1_col_r;

  logic            fw_v_r, fw_v_nxt;
  dch_pkg::bin_t   fw_bin_r;
  dch_pkg::count_t fw_cnt_r;

  dch_pkg::count_t best_cnt_r, best_cnt_nxt;
  dch_pkg::bin_t   best_bin_r, best_bin_nxt;
  dch_pkg::epoch_t epoch_r, epoch_nxt;
  logic            clr_busy_r, clr_busy_nxt;
  dch_pkg::bin_t   clr_addr_r, clr_addr_nxt;

  logic [dch_pkg::MINB_BITS-1:0] sum;
  logic            acc_q;
  dch_pkg::bin_t   acc_bin;
  dch_pkg::count_t cnt_old, cnt_new, fin_cnt;
  dch_pkg::bin_t   fin_bin;
  logic            wr_en, best_upd, frame_end, wrap;

  assign sum = dch_pkg::MINB_BITS'(color_i.red) + dch_pkg::MINB_BITS'(color_i.green)
             + dch_pkg::MINB_BITS'(color_i.blue);
  assign acc_q   = (sum >= min_bright_i);
  assign acc_bin = dch_pkg::bin_of(color_i);

  always_comb begin
    if (fw_v_r && (fw_bin_r == s1_bin_r)) begin
      cnt_old = fw_cnt_r;
    end else if (rd_r.tag == epoch_r) begin
      cnt_old = rd_r.cnt;
    end else begin
      cnt_old = '0;
    end
    cnt_new = (cnt_old == dch_pkg::COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
  end

  assign wr_en     = s1_v_r && s1_q_r;
  assign frame_end = s1_v_r && s1_last_r;
  assign wrap      = frame_end && (epoch_r == dch_pkg::EPOCH_MAX);
  assign best_upd  = wr_en && ((cnt_new > best_cnt_r) ||
                     ((cnt_new == best_cnt_r) && (s1_bin_r < best_bin_r)));
  assign fin_cnt   = best_upd ? cnt_new : best_cnt_r;
  assign fin_bin   = best_upd ? s1_bin_r : best_bin_r;

  always_comb begin
    s1_v_nxt     = acc_i;
    fw_v_nxt     = wr_en && !s1_last_r;
    best_cnt_nxt = frame_end ? '0 : fin_cnt;
    best_bin_nxt = frame_end ? '0 : fin_bin;
    epoch_nxt    = epoch_r;
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == '1) clr_busy_nxt = 1'b0;
    end
    if (wrap) begin
      epoch_nxt    = dch_pkg::EPOCH_INIT;
      clr_busy_nxt = 1'b1;
      clr_addr_nxt = '0;
    end else if (frame_end) begin
      epoch_nxt = epoch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      fw_v_r     <= 1'b0;
      best_cnt_r <= '0;
      best_bin_r <= '0;
      epoch_r    <= dch_pkg::EPOCH_INIT;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      s1_v_r     <= s1_v_nxt;
      fw_v_r     <= fw_v_nxt;
      best_cnt_r <= best_cnt_nxt;
      best_bin_r <= best_bin_nxt;
      epoch_r    <= epoch_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i) begin
      s1_last_r <= last_i;
      s1_q_r    <= acc_q;
      s1_bin_r  <= acc_bin;
      s1_col_r  <= color_i;
    end
    fw_bin_r <= s1_bin_r;
    fw_cnt_r <= cnt_new;
  end

  // tag zero is never a live epoch, so a swept entry reads as empty
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      cnt_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      cnt_mem[s1_bin_r] <= '{tag: epoch_r, cnt: cnt_new};
    end
    if (acc_i) rd_r <= cnt_mem[acc_bin];
  end

  always_comb begin
    req_o.wr_en        = wr_en;
    req_o.wr_bin       = s1_bin_r;
    req_o.wr_color     = s1_col_r;
    req_o.rq_valid     = frame_end;
    req_o.rq_bin       = fin_bin;
    req_o.rq_fwd       = wr_en && (fin_bin == s1_bin_r);
    req_o.rq_fwd_color = s1_col_r;
    req_o.rq_found     = (fin_cnt != '0);
    req_o.rq_peak      = dch_pkg::sat_peak(fin_cnt);
    sts_o.busy         = clr_busy_r || wrap;
    sts_o.last_in_s1   = frame_end;
  end

`ifndef ASSERT_OFF
  a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_v_r)
    else $error("pixel in update stage during clearing sweep");

  a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (best_cnt_r == '0) && (best_bin_r == '0))
    else $error("running best not cleared after frame end");

  a_fwd_live_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    fw_v_r |-> $stable(epoch_r))
    else $error("forwarded count crosses a frame boundary");
`endif

endmodule

@@ rtl/core/dch_color_store.sv @@
// dch_color_store: per-bin last colour memory and the result build stage.
// Uses dch_pkg.

module dch_color_store (
  input  logic                clk,
  input  logic                rst_n,
  input  dch_pkg::color_req_t req_i,
  output logic                res_v_o,
  output dch_pkg::result_t    res_o
);

  dch_pkg::color_t col_mem [dch_pkg::NUM_BINS];
  dch_pkg::color_t rd_r;

  logic            s2_v_r;
  logic            s2_fwd_r;
  dch_pkg::color_t s2_fwd_col_r;
  logic            s2_found_r;
  dch_pkg::peak_t  s2_peak_r;

  always_ff @(posedge clk) begin
    if (req_i.wr_en) col_mem[req_i.wr_bin] <= req_i.wr_color;
    if (req_i.rq_valid) rd_r <= col_mem[req_i.rq_bin];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= req_i.rq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.rq_valid) begin
      s2_fwd_r     <= req_i.rq_fwd;
      s2_fwd_col_r <= req_i.rq_fwd_color;
      s2_found_r   <= req_i.rq_found;
      s2_peak_r    <= req_i.rq_peak;
    end
  end

  always_comb begin
    res_v_o     = s2_v_r;
    res_o.found = s2_found_r;
    res_o.peak  = s2_found_r ? s2_peak_r : '0;
    if (!s2_found_r) begin
      res_o.color = '{red: dch_pkg::GREY_LEVEL, green: dch_pkg::GREY_LEVEL,
                      blue: dch_pkg::GREY_LEVEL};
    end else if (s2_fwd_r) begin
      res_o.color = s2_fwd_col_r;
    end else begin
      res_o.color = rd_r;
    end
  end

endmodule

@@ rtl/core/dch_result_fifo.sv @@
// dch_result_fifo: two-entry result queue in front of the output channel.
// Uses dch_pkg.

module dch_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  dch_pkg::result_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output dch_pkg::result_t data_o,
  output logic [1:0]       cnt_o
);

  dch_pkg::result_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign valid_o = (cnt_r != 2'd0);
  assign data_o  = slot_r[rd_ptr_r];
  assign cnt_o   = cnt_r;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push_i && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) slot_r[wr_ptr_r] <= push_data_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (cnt_r != 2'd2) || do_pop)
    else $error("result pushed into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");
`endif

endmodule

@@ rtl/core/dominant_color_histogram.sv @@
// dominant_color_histogram: top level, threshold register, input stall and
// output channel. Uses dch_pkg, dch_bin_update, dch_color_store, dch_result_fifo.
//
//   channel | ports                                   | moves
//   in      | in_valid, in_stall, in_pixel_*, in_last | one pixel per beat
//   out     | out_valid, out_stall, out_dominant_*,.. | one result per frame
//   cfg     | cfg_we, cfg_wdata                       | min_brightness write
//
// One pixel per cycle while in_stall is low. out_valid for a frame's result
// rises once its last pixel beat has passed the update stage, the colour store
// stage and the two-entry result queue. After reset the count memory is swept
// with in_stall high; the same sweep follows every 255th frame (epoch tag wrap).
// in_stall is also high while two results are queued or in flight.

module dominant_color_histogram (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_pixel_red,
  input  logic [7:0]             in_pixel_green,
  input  logic [7:0]             in_pixel_blue,
  input  logic                   in_last_pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_dominant_red,
  output logic [7:0]             out_dominant_green,
  output logic [7:0]             out_dominant_blue,
  output logic                   out_found,
  output logic [19:0]            out_peak_count,
  input  logic                   cfg_we,
  input  logic [9:0]             cfg_wdata
);

  dch_pkg::minb_t       min_bright_r;
  dch_pkg::color_t      in_color;
  dch_pkg::color_req_t  req;
  dch_pkg::upd_status_t sts;
  dch_pkg::result_t     res, head;
  logic                 res_v, acc;
  logic [1:0]           q_cnt;
  logic [2:0]           pend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bright_r <= dch_pkg::MINB_RESET;
    end else if (cfg_we) begin
      min_bright_r <= cfg_wdata;
    end
  end

  assign in_color = '{red: in_pixel_red, green: in_pixel_green, blue: in_pixel_blue};
  assign pend     = 3'(q_cnt) + 3'(sts.last_in_s1) + 3'(res_v);
  assign in_stall = sts.busy || (pend >= 3'd2);
  assign acc      = in_valid && !in_stall;

  dch_bin_update u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_i        (acc),
    .color_i      (in_color),
    .last_i       (in_last_pixel),
    .min_bright_i (min_bright_r),
    .req_o        (req),
    .sts_o        (sts)
  );

  dch_color_store u_color (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_i   (req),
    .res_v_o (res_v),
    .res_o   (res)
  );

  dch_result_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_v),
    .push_data_i (res),
    .pop_i       (!out_stall),
    .valid_o     (out_valid),
    .data_o      (head),
    .cnt_o       (q_cnt)
  );

  assign out_dominant_red   = head.color.red;
  assign out_dominant_green = head.color.green;
  assign out_dominant_blue  = head.color.blue;
  assign out_found          = head.found;
  assign out_peak_count     = head.peak;

endmodule

@@ sim/tb_dominant_color_histogram.sv @@
// tb_dominant_color_histogram: self-checking testbench for the dominant colour
// histogram. Needs dch_pkg and the dominant_color_histogram RTL; a behavioural
// histogram predicts each frame result and a monitor checks every output beat.

module tb_dominant_color_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  dch_pkg::chan_t  in_pixel_red = '0;
  dch_pkg::chan_t  in_pixel_green = '0;
  dch_pkg::chan_t  in_pixel_blue = '0;
  logic            in_last_pixel = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  dch_pkg::chan_t  out_dominant_red;
  dch_pkg::chan_t  out_dominant_green;
  dch_pkg::chan_t  out_dominant_blue;
  logic            out_found;
  dch_pkg::peak_t  out_peak_count;
  logic            cfg_we = 1'b0;
  dch_pkg::minb_t  cfg_wdata = '0;

  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold = 0;
  int          bad_results = 0;
  int unsigned cycles = 0;

  // frame histogram, running leader and threshold as the block should hold them
  dch_pkg::count_t  hist_count [int];
  dch_pkg::color_t  hist_color [int];
  dch_pkg::count_t  lead_count = '0;
  dch_pkg::bin_t    lead_bin = '0;
  dch_pkg::minb_t   min_bright = dch_pkg::MINB_RESET;
  dch_pkg::result_t frame_results [$];

  dominant_color_histogram DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel_red       (in_pixel_red),
    .in_pixel_green     (in_pixel_green),
    .in_pixel_blue      (in_pixel_blue),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_dominant_red   (out_dominant_red),
    .out_dominant_green (out_dominant_green),
    .out_dominant_blue  (out_dominant_blue),
    .out_found          (out_found),
    .out_peak_count     (out_peak_count),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void tally_pixel(dch_pkg::chan_t r, dch_pkg::chan_t g,
                                      dch_pkg::chan_t b, logic last);
    dch_pkg::color_t  px;
    dch_pkg::bin_t    bin;
    dch_pkg::count_t  c;
    dch_pkg::result_t res;
    px = {r, g, b};
    if (int'(r) + int'(g) + int'(b) >= int'(min_bright)) begin
      bin = {r[7:3], g[7:3], b[7:3]};
      c = hist_count.exists(int'(bin)) ? hist_count[int'(bin)] : '0;
      if (c != dch_pkg::COUNT_MAX) c = c + 1'b1;
      hist_count[int'(bin)] = c;
      hist_color[int'(bin)] = px;
      if (c > lead_count || (c == lead_count && bin < lead_bin)) begin
        lead_count = c;
        lead_bin = bin;
      end
    end
    if (last) begin
      if (lead_count != '0) begin
        res.color = hist_color[int'(lead_bin)];
        res.found = 1'b1;
        res.peak = (lead_count > dch_pkg::PEAK_MAX) ? dch_pkg::PEAK_MAX
                                                    : dch_pkg::peak_t'(lead_count);
      end else begin
        res.color = {dch_pkg::GREY_LEVEL, dch_pkg::GREY_LEVEL, dch_pkg::GREY_LEVEL};
        res.found = 1'b0;
        res.peak = '0;
      end
      frame_results.push_back(res);
      hist_count.delete();
      lead_count = '0;
      lead_bin = '0;
    end
  endfunction

  task automatic push_pixel(dch_pkg::chan_t r, dch_pkg::chan_t g, dch_pkg::chan_t b,
                            logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_red <= r;
    in_pixel_green <= g;
    in_pixel_blue <= b;
    in_last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tally_pixel(r, g, b, last);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_threshold(dch_pkg::minb_t v);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    min_bright = v;
  endtask

  task automatic push_random_pixel(dch_pkg::color_t palette [8], logic last);
    dch_pkg::color_t base;
    int              pick;
    pick = $urandom_range(99);
    base = palette[$urandom_range(7)];
    if (pick < 75)
      push_pixel({base.red[7:3], 3'($urandom)}, {base.green[7:3], 3'($urandom)},
                 {base.blue[7:3], 3'($urandom)}, last);
    else if (pick < 90)
      push_pixel(dch_pkg::chan_t'($urandom), dch_pkg::chan_t'($urandom),
                 dch_pkg::chan_t'($urandom), last);
    else
      push_pixel(dch_pkg::chan_t'($urandom_range(40)), dch_pkg::chan_t'($urandom_range(40)),
                 dch_pkg::chan_t'($urandom_range(40)), last);
  endtask

  task automatic test_default_threshold();
    push_pixel(8'd20, 8'd20, 8'd19, 1'b0);
    push_pixel(8'd20, 8'd20, 8'd19, 1'b1);
    push_pixel(8'd20, 8'd20, 8'd20, 1'b1);
    push_pixel(8'd200, 8'd10, 8'd10, 1'b0);
    push_pixel(8'd1, 8'd2, 8'd3, 1'b1);
  endtask

  task automatic test_channel_extremes();
    set_threshold(dch_pkg::minb_t'(0));
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd248, 8'd249, 8'd250, 1'b1);
    push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 1'b1);
  endtask

  task automatic test_tie_break();
    push_pixel(8'd64, 8'd64, 8'd64, 1'b0);
    push_pixel(8'd8, 8'd8, 8'd8, 1'b1);
    push_pixel(8'd8, 8'd8, 8'd8, 1'b0);
    push_pixel(8'd64, 8'd64, 8'd64, 1'b0);
    push_pixel(8'd70, 8'd66, 8'd65, 1'b1);
  endtask

  task automatic test_threshold_limits();
    set_threshold(dch_pkg::minb_t'(765));
    push_pixel(8'd255, 8'd255, 8'd254, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    set_threshold(dch_pkg::minb_t'(766));
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
  endtask

  // enough frames to pass the epoch tag wrap and its sweep
  task automatic test_short_frames(int frames);
    dch_pkg::color_t palette [8];
    foreach (palette[i]) palette[i] = dch_pkg::color_t'($urandom);
    set_threshold(dch_pkg::MINB_RESET);
    for (int f = 0; f < frames; f++) begin
      if ($urandom_range(1)) push_random_pixel(palette, 1'b0);
      push_random_pixel(palette, 1'b1);
    end
  endtask

  task automatic test_backpressure();
    dch_pkg::color_t palette [8];
    foreach (palette[i]) palette[i] = dch_pkg::color_t'($urandom);
    settle();
    rx_hold = 300;
    for (int f = 0; f < 12; f++) begin
      push_random_pixel(palette, 1'b0);
      push_random_pixel(palette, 1'b0);
      push_random_pixel(palette, 1'b1);
    end
    settle();
  endtask

  task automatic test_random_frames(int items, int gap, int stall);
    dch_pkg::color_t palette [8];
    int              len;
    int              sent;
    tx_gap_pct = gap;
    rx_stall_pct = stall;
    foreach (palette[i]) palette[i] = dch_pkg::color_t'($urandom);
    set_threshold(dch_pkg::minb_t'($urandom_range(400)));
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) push_random_pixel(palette, i == len - 1);
      sent += len;
    end
  endtask

  // one bin hit again and again; its colour keeps being overwritten
  task automatic test_repeated_bin();
    set_threshold(dch_pkg::minb_t'(0));
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    for (int i = 0; i < 24; i++)
      push_pixel({5'd12, 3'($urandom)}, {5'd12, 3'($urandom)},
                 {5'd12, 3'($urandom)}, 1'b0);
    push_pixel(8'd101, 8'd102, 8'd103, 1'b1);
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    dch_pkg::result_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result beat: %0d,%0d,%0d found=%0b peak=%0d",
                   out_dominant_red, out_dominant_green, out_dominant_blue,
                   out_found, out_peak_count);
      end else begin
        exp = frame_results.pop_front();
        if (out_dominant_red !== exp.color.red || out_dominant_green !== exp.color.green ||
            out_dominant_blue !== exp.color.blue || out_found !== exp.found ||
            out_peak_count !== exp.peak) begin
          bad_results++;
          if (bad_results <= 10)
            $display({"result mismatch: exp %0d,%0d,%0d found=%0b peak=%0d",
                      " got %0d,%0d,%0d found=%0b peak=%0d"},
                     exp.color.red, exp.color.green, exp.color.blue, exp.found, exp.peak,
                     out_dominant_red, out_dominant_green, out_dominant_blue,
                     out_found, out_peak_count);
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("dominant_color_histogram test failed");
    $finish;
  end

  initial begin
    tx_gap_pct = 9;
    rx_stall_pct = 48;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_threshold();
    test_channel_extremes();
    test_tie_break();
    test_threshold_limits();
    test_short_frames(280);
    test_backpressure();
    test_random_frames(100, 9, 48);
    test_random_frames(100, 48, 9);
    test_random_frames(100, 0, 0);
    test_repeated_bin();

    settle();
    repeat (16) @(posedge clk);
    bad_results += frame_results.size();
    if (bad_results == 0)
      $display("dominant_color_histogram test passed");
    else
      $display("dominant_color_histogram test failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dch_pkg.sv
rtl/core/dch_bin_update.sv
rtl/core/dch_color_store.sv
rtl/core/dch_result_fifo.sv
rtl/core/dominant_color_histogram.sv
sim/tb_dominant_color_histogram.sv
